// ===== design/fbrcd_pkg.sv =====
// Package for the feedback report change detector.
// Holds the shared widths, byte codes, state types and the parser command struct.
// No dependencies.
package fbrcd_pkg;

   localparam int MAX_MODULES       = 31;
   localparam int INPUTS_PER_MODULE = 16;
   localparam int ADDRESS_BASE      = 1;

   localparam int BYTE_W  = 8;
   localparam int MOD_W   = 5;
   localparam int BITS_W  = INPUTS_PER_MODULE;
   localparam int BIT_W   = $clog2(INPUTS_PER_MODULE);
   localparam int CH_W    = 2;
   localparam int ADDR_W  = 9;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] CR_BYTE     = 8'd13;
   localparam logic [BYTE_W-1:0] TYPE_INPUTS = 8'h69;
   localparam logic [BYTE_W-1:0] TYPE_SETUP  = 8'h73;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_MODULES   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE_MODULES = 1'd1;

   // positions within a triple
   localparam logic [1:0] TP_MODULE = 2'd0;
   localparam logic [1:0] TP_HIGH   = 2'd1;
   localparam logic [1:0] TP_LOW    = 2'd2;

   // result kinds and channels
   localparam logic       KIND_CHANGE = 1'b0;
   localparam logic       KIND_RANGE  = 1'b1;
   localparam logic [CH_W-1:0] CH_LEFT   = 2'd0;
   localparam logic [CH_W-1:0] CH_MIDDLE = 2'd1;
   localparam logic [CH_W-1:0] CH_RIGHT  = 2'd2;

   typedef enum logic [1:0] {
      PH_START,
      PH_COUNT,
      PH_TRIPLES,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      EV_IDLE,
      EV_SCAN,
      EV_RANGE
   } ev_state_type;

   // command from the frame parser to the event unit
   typedef struct packed {
      logic              start;
      logic              err;
      logic              clear_known;
      logic [BYTE_W-1:0] module_num;
      logic [BITS_W-1:0] bits;
   } ev_cmd_type;

endpackage

// ===== design/fbrcd_parser.sv =====
// Frame parser: splits received bytes into frames and assembles triples.
// Depends on fbrcd_pkg; issues commands to fbrcd_event_unit.
module fbrcd_parser import fbrcd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] rx_byte,
   output ev_cmd_type        cmd
);

   phase_type         phase_ff, phase_in;
   logic              setup_ff, setup_in;
   logic [BYTE_W-1:0] left_ff, left_in;
   logic [1:0]        pos_ff, pos_in;
   logic [BYTE_W-1:0] module_ff, module_in;
   logic [BYTE_W-1:0] high_ff, high_in;
   logic [MOD_W-1:0]  reg_mods_ff, reg_mods_in;
   logic              is_cr;
   logic              triple_done;

   assign is_cr = (rx_byte == CR_BYTE);

   // next state of the frame sequencer
   always_comb begin
      phase_in    = phase_ff;
      setup_in    = setup_ff;
      left_in     = left_ff;
      pos_in      = pos_ff;
      module_in   = module_ff;
      high_in     = high_ff;
      reg_mods_in = reg_mods_ff;
      if (accept) begin
         if (is_cr) begin
            phase_in = PH_START;
            pos_in   = TP_MODULE;
            left_in  = '0;
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  setup_in = (rx_byte == TYPE_SETUP);
                  phase_in = (rx_byte == TYPE_INPUTS || rx_byte == TYPE_SETUP) ?
                             PH_COUNT : PH_SKIP;
               end
               PH_COUNT: begin
                  if (setup_ff) begin
                     reg_mods_in = (rx_byte > BYTE_W'(MAX_MODULES)) ?
                                   MOD_W'(MAX_MODULES) : rx_byte[MOD_W-1:0];
                     phase_in    = PH_SKIP;
                  end else begin
                     left_in  = rx_byte;
                     pos_in   = TP_MODULE;
                     phase_in = PH_TRIPLES;
                  end
               end
               PH_TRIPLES: begin
                  if (left_ff != '0) begin
                     unique case (pos_ff)
                        TP_MODULE: begin
                           module_in = rx_byte;
                           pos_in    = TP_HIGH;
                        end
                        TP_HIGH: begin
                           high_in = rx_byte;
                           pos_in  = TP_LOW;
                        end
                        default: begin
                           pos_in  = TP_MODULE;
                           left_in = left_ff - 8'd1;
                        end
                     endcase
                  end
               end
               PH_SKIP: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   // commands to the event unit
   always_comb begin
      triple_done = accept && !is_cr && (phase_ff == PH_TRIPLES) &&
                    (left_ff != '0) && (pos_ff != TP_MODULE) && (pos_ff != TP_HIGH);
      cmd.start       = triple_done;
      cmd.err         = (module_ff == '0) || (module_ff > {3'b000, reg_mods_ff});
      cmd.clear_known = accept && !is_cr && (phase_ff == PH_COUNT) && setup_ff;
      cmd.module_num  = module_ff;
      cmd.bits        = {high_ff, rx_byte};
   end

   // hold the parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         setup_ff    <= 1'b0;
         left_ff     <= '0;
         pos_ff      <= TP_MODULE;
         module_ff   <= '0;
         high_ff     <= '0;
         reg_mods_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         setup_ff    <= setup_in;
         left_ff     <= left_in;
         pos_ff      <= pos_in;
         module_ff   <= module_in;
         high_ff     <= high_in;
         reg_mods_ff <= reg_mods_in;
      end
   end

endmodule

// ===== design/fbrcd_event_unit.sv =====
// Event unit: stores module bits and walks the sixteen inputs of a triple,
// one bit a cycle unless the output stalls, through a shared compare and
// address mapper. Depends on fbrcd_pkg; driven by fbrcd_parser.
module fbrcd_event_unit import fbrcd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ev_cmd_type        cmd,
   input  logic [MOD_W-1:0]  left_modules,
   input  logic [MOD_W-1:0]  middle_modules,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [CH_W-1:0]   rsp_channel,
   output logic [ADDR_W-1:0] rsp_address,
   output logic              rsp_level,
   output logic              rsp_last
);

   ev_state_type      state_ff, state_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [BITS_W-1:0] mask_ff, mask_in;
   logic [BITS_W-1:0] new_ff, new_in;
   logic [MOD_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] range_mod_ff, range_mod_in;

   logic [BITS_W-1:0] module_bits_ff [0:MAX_MODULES-1];
   logic [MAX_MODULES-1:0] known_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic [CH_W-1:0]   rsp_channel_ff;
   logic [ADDR_W-1:0] rsp_address_ff;
   logic              rsp_level_ff;
   logic              rsp_last_ff;

   logic [MOD_W-1:0]  start_idx;
   logic [BITS_W-1:0] start_mask;
   logic              out_free;
   logic              emit_change;
   logic              emit_range;
   logic              step;
   logic              change_last;

   logic [MOD_W:0]    lm, mm, idx6, base, rel;
   logic [CH_W-1:0]   map_ch;
   logic [ADDR_W-1:0] map_addr;

   // difference mask of a new triple
   always_comb begin
      start_idx  = cmd.module_num[MOD_W-1:0] - 5'd1;
      start_mask = known_ff[start_idx] ? (cmd.bits ^ module_bits_ff[start_idx]) : '1;
   end

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign change_last = ((mask_ff >> bit_ff) == BITS_W'(1));

   // map the current input onto its chain
   always_comb begin
      lm   = {1'b0, left_modules};
      mm   = {1'b0, left_modules} + {1'b0, middle_modules};
      idx6 = {1'b0, idx_ff};
      if (idx6 < lm) begin
         map_ch = CH_LEFT;
         base   = '0;
      end else if (idx6 < mm) begin
         map_ch = CH_MIDDLE;
         base   = lm;
      end else begin
         map_ch = CH_RIGHT;
         base   = mm;
      end
      rel      = idx6 - base;
      map_addr = {rel[MOD_W-1:0], bit_ff} + ADDR_W'(ADDRESS_BASE);
   end

   // sequencer outputs
   always_comb begin
      emit_change = 1'b0;
      emit_range  = 1'b0;
      step        = 1'b0;
      unique case (state_ff)
         EV_SCAN: begin
            emit_change = mask_ff[bit_ff] && out_free;
            step        = !mask_ff[bit_ff] || out_free;
         end
         EV_RANGE: emit_range = out_free;
         default: begin
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      bit_in       = bit_ff;
      mask_in      = mask_ff;
      new_in       = new_ff;
      idx_in       = idx_ff;
      range_mod_in = range_mod_ff;
      unique case (state_ff)
         EV_IDLE: begin
            if (cmd.start) begin
               range_mod_in = cmd.module_num;
               idx_in       = start_idx;
               new_in       = cmd.bits;
               mask_in      = start_mask;
               bit_in       = '0;
               if (cmd.err) begin
                  state_in = EV_RANGE;
               end else if (start_mask != '0) begin
                  state_in = EV_SCAN;
               end
            end
         end
         EV_SCAN: begin
            if (step) begin
               bit_in = bit_ff + 4'd1;
               if (bit_ff == BIT_W'(INPUTS_PER_MODULE - 1)) begin
                  state_in = EV_IDLE;
               end
            end
         end
         EV_RANGE: begin
            if (emit_range) begin
               state_in = EV_IDLE;
            end
         end
         default: state_in = EV_IDLE;
      endcase
   end

   assign busy = (state_ff != EV_IDLE);

   // advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bit_ff       <= bit_in;
      mask_ff      <= mask_in;
      new_ff       <= new_in;
      idx_ff       <= idx_in;
      range_mod_ff <= range_mod_in;
   end

   // store module bits and known flags
   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
      end else if (cmd.clear_known) begin
         known_ff <= '0;
      end else if (cmd.start && !cmd.err && state_ff == EV_IDLE) begin
         known_ff[start_idx] <= 1'b1;
      end
      if (cmd.start && !cmd.err && state_ff == EV_IDLE) begin
         module_bits_ff[start_idx] <= cmd.bits;
      end
   end

   // output register
   always_comb begin
      if (emit_change || emit_range) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit_change) begin
         rsp_kind_ff    <= KIND_CHANGE;
         rsp_channel_ff <= map_ch;
         rsp_address_ff <= map_addr;
         rsp_level_ff   <= new_ff[bit_ff];
         rsp_last_ff    <= change_last;
      end else if (emit_range) begin
         rsp_kind_ff    <= KIND_RANGE;
         rsp_channel_ff <= CH_LEFT;
         rsp_address_ff <= {1'b0, range_mod_ff};
         rsp_level_ff   <= 1'b0;
         rsp_last_ff    <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_level   = rsp_level_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ===== design/feedback_report_change_detector_top.sv =====
// Throughput: a byte that ends a triple holds the input while the event unit
// walks the sixteen inputs (if any bit changed), one bit a cycle, or reports
// a range error; other bytes do not hold it, and output stalls prolong the hold.
// Reset (synchronous) marks every module unknown, clears the module count and
// sets both chain sizes to 2.
// Top level: configuration registers, frame parser and event unit.
// Depends on fbrcd_pkg, fbrcd_parser and fbrcd_event_unit.
module feedback_report_change_detector_top import fbrcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [CH_W-1:0]      rsp_channel,
   output logic [ADDR_W-1:0]    rsp_address,
   output logic                 rsp_level,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MOD_W-1:0]     csr_data
);

   logic [MOD_W-1:0] left_ff, middle_ff;
   logic             busy;
   logic             accept;
   ev_cmd_type       cmd;

   assign csr_ready = 1'b1;
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   // write chain sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= MOD_W'(2);
         middle_ff <= MOD_W'(2);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LEFT_MODULES:   left_ff   <= csr_data;
            REG_MIDDLE_MODULES: middle_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   fbrcd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .cmd     (cmd)
   );

   fbrcd_event_unit u_event (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .left_modules   (left_ff),
      .middle_modules (middle_ff),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_channel    (rsp_channel),
      .rsp_address    (rsp_address),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== design/fbrcd_checker.sv =====
// Port checker for the feedback report change detector, bound to the top level.
// Depends on fbrcd_pkg.
module fbrcd_checker import fbrcd_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [BYTE_W-1:0]    req_rx_byte,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_kind,
   input logic [CH_W-1:0]      rsp_channel,
   input logic [ADDR_W-1:0]    rsp_address,
   input logic                 rsp_level,
   input logic                 rsp_last,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [MOD_W-1:0]     csr_data
);

   // hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_channel) && $stable(rsp_address) && $stable(rsp_level) &&
      $stable(rsp_last))
      else $error("result item changed while stalled");

   // a range error is marked last and reported on the left channel
   a_range_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RANGE |-> rsp_last && rsp_channel == CH_LEFT)
      else $error("range error not marked last");

   // change events carry a real channel and a non-zero address
   a_change_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CHANGE |->
      rsp_channel != 2'd3 && rsp_address != '0)
      else $error("change event mapped outside its chain");

   // a frame end starts no work
   a_cr_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_rx_byte == CR_BYTE |=> req_ready)
      else $error("input stalled after frame end");

endmodule

bind feedback_report_change_detector_top fbrcd_checker u_fbrcd_checker (.*);

// ===== tb/sv/feedback_report_change_detector_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for feedback_report_change_detector_top: drives serial bytes,
// predicts the change and range events, and checks every result item in order.
// Depends on fbrcd_pkg and the design under test only.
module feedback_report_change_detector_top_tb;
   import fbrcd_pkg::*;

   // one expected result item
   typedef struct packed {
      logic              kind;
      logic [CH_W-1:0]   channel;
      logic [ADDR_W-1:0] address;
      logic              level;
      logic              last;
   } change_event_type;

   typedef struct {
      logic [CSR_IDX_W-1:0] reg_index;
      logic [MOD_W-1:0]     reg_value;
   } chain_write_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_kind;
   logic [CH_W-1:0]      rsp_channel;
   logic [ADDR_W-1:0]    rsp_address;
   logic                 rsp_level;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MOD_W-1:0]     csr_data = '0;

   feedback_report_change_detector_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_channel (rsp_channel),
      .rsp_address (rsp_address),
      .rsp_level   (rsp_level),
      .rsp_last    (rsp_last),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   // stimulus and expectation stores
   logic [BYTE_W-1:0] pending_bytes [$];
   chain_write_type   pending_writes [$];
   change_event_type  expected_events [$];
   int                error_count = 0;
   int                byte_total = 0;
   bit                calm_phase = 1'b0;
   int                hold_asks = 0;
   int                hold_done = 0;
   int                req_gap = 0;
   int                rsp_gap = 0;
   int                rsp_hold = 0;

   // chain sizes as last written
   int                left_count = 2;
   int                middle_count = 2;

   // frame tracker state
   phase_type         parse_phase = PH_START;
   logic [BYTE_W-1:0] frame_kind = '0;
   logic [BYTE_W-1:0] triples_remaining = '0;
   logic [1:0]        triple_slot = TP_MODULE;
   logic [BYTE_W-1:0] held_module = '0;
   logic [BYTE_W-1:0] held_high = '0;
   int                module_count = 0;
   logic [BITS_W-1:0] stored_bits [MAX_MODULES];
   logic [MAX_MODULES-1:0] known = '0;

   // generator's own notion of the module count and last pattern sent
   int                gen_count = 0;
   bit [BITS_W-1:0]   last_sent [256];

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // advance the frame tracker by one byte and queue the events it causes
   function automatic void track_rx_byte(logic [BYTE_W-1:0] b);
      logic [BITS_W-1:0] fresh;
      logic [BITS_W-1:0] flips;
      int                idx;
      int                flat;
      change_event_type  ev;
      if (b == CR_BYTE) begin
         parse_phase = PH_START;
         triple_slot = TP_MODULE;
         triples_remaining = '0;
         return;
      end
      case (parse_phase)
         PH_START: begin
            frame_kind = b;
            parse_phase = (b == TYPE_INPUTS || b == TYPE_SETUP) ? PH_COUNT : PH_SKIP;
         end
         PH_COUNT: begin
            if (frame_kind == TYPE_SETUP) begin
               module_count = (b > MAX_MODULES) ? MAX_MODULES : int'(b);
               known = '0;
               parse_phase = PH_SKIP;
            end else begin
               triples_remaining = b;
               triple_slot = TP_MODULE;
               parse_phase = PH_TRIPLES;
            end
         end
         PH_TRIPLES: begin
            if (triples_remaining != 0) begin
               case (triple_slot)
                  TP_MODULE: begin
                     held_module = b;
                     triple_slot = TP_HIGH;
                  end
                  TP_HIGH: begin
                     held_high = b;
                     triple_slot = TP_LOW;
                  end
                  default: begin
                     triple_slot = TP_MODULE;
                     triples_remaining = triples_remaining - 8'd1;
                     if (held_module == 0 || held_module > module_count) begin
                        ev.kind = KIND_RANGE;
                        ev.channel = CH_LEFT;
                        ev.address = ADDR_W'(held_module);
                        ev.level = 1'b0;
                        ev.last = 1'b1;
                        expected_events.push_back(ev);
                     end else begin
                        idx = int'(held_module) - 1;
                        fresh = {held_high, b};
                        flips = known[idx] ? (fresh ^ stored_bits[idx]) : '1;
                        for (int j = 0; j < BITS_W; j++) begin
                           if (flips[j]) begin
                              flat = idx * INPUTS_PER_MODULE + j;
                              ev.kind = KIND_CHANGE;
                              ev.level = fresh[j];
                              ev.last = ((flips >> (j + 1)) == 0);
                              if (idx < left_count) begin
                                 ev.channel = CH_LEFT;
                                 ev.address = ADDR_W'(flat + ADDRESS_BASE);
                              end else if (idx < left_count + middle_count) begin
                                 ev.channel = CH_MIDDLE;
                                 ev.address = ADDR_W'(flat - left_count * INPUTS_PER_MODULE
                                                      + ADDRESS_BASE);
                              end else begin
                                 ev.channel = CH_RIGHT;
                                 ev.address = ADDR_W'(flat - (left_count + middle_count)
                                                      * INPUTS_PER_MODULE + ADDRESS_BASE);
                              end
                              expected_events.push_back(ev);
                           end
                        end
                        stored_bits[idx] = fresh;
                        known[idx] = 1'b1;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         if (error_count < 40)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // byte driver: predict on acceptance, then offer the next byte after its gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            track_rx_byte(req_rx_byte);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_rx_byte <= pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_gap = calm_phase ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // chain size writes: track the values as they are taken
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_LEFT_MODULES)
               left_count = int'(csr_data);
            else if (csr_index == REG_MIDDLE_MODULES)
               middle_count = int'(csr_data);
         end
         if (!csr_valid || csr_ready) begin
            if (pending_writes.size() != 0) begin
               csr_index <= pending_writes[0].reg_index;
               csr_data <= pending_writes[0].reg_value;
               csr_valid <= 1'b1;
               void'(pending_writes.pop_front());
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: check each item against the oldest expectation, stall at random
   always @(posedge clock) begin : result_watch
      change_event_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               if (error_count < 40)
                  $display("%0t: unexpected item, expected none, got kind %0d ch %0d addr %0d",
                           $time, rsp_kind, rsp_channel, rsp_address);
               error_count++;
            end else begin
               want = expected_events.pop_front();
               compare_field("kind", want.kind, rsp_kind);
               compare_field("channel", want.channel, rsp_channel);
               compare_field("address", want.address, rsp_address);
               compare_field("level", want.level, rsp_level);
               compare_field("last", want.last, rsp_last);
            end
         end
         if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            rsp_hold = 400;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm_phase && $urandom_range(3) == 0)
               rsp_gap = pick_gap();
         end
      end
   end

   task automatic push_byte(logic [BYTE_W-1:0] b);
      pending_bytes.push_back(b);
      byte_total++;
   endtask

   task automatic push_triple(int m, logic [BITS_W-1:0] bits);
      push_byte(BYTE_W'(m));
      push_byte(bits[15:8]);
      push_byte(bits[7:0]);
      last_sent[m[7:0]] = bits;
   endtask

   // hold until every byte is taken and every result has come, then let the block settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (24) @(negedge clock);
   endtask

   task automatic set_chains(int left, int middle);
      chain_write_type w;
      w.reg_index = REG_LEFT_MODULES;
      w.reg_value = MOD_W'(left);
      pending_writes.push_back(w);
      w.reg_index = REG_MIDDLE_MODULES;
      w.reg_value = MOD_W'(middle);
      pending_writes.push_back(w);
      do @(negedge clock);
      while (pending_writes.size() != 0 || csr_valid);
   endtask

   // mostly well-formed frames with random content, plus noise and broken frames
   task automatic random_phase(int budget);
      int start;
      int pick;
      int n;
      int announced;
      int m;
      logic [BITS_W-1:0] bits;
      start = byte_total;
      while (byte_total - start < budget) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            n = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, MAX_MODULES);
            push_byte(TYPE_SETUP);
            push_byte(BYTE_W'(n));
            if ($urandom_range(3) == 0)
               push_byte(BYTE_W'($urandom_range(255)));
            push_byte(CR_BYTE);
            gen_count = (n > MAX_MODULES) ? MAX_MODULES : n;
         end else if (pick < 75) begin
            n = $urandom_range(1, 3);
            case ($urandom_range(9))
               0: announced = n - 1;
               1: announced = n + 1;
               default: announced = n;
            endcase
            push_byte(TYPE_INPUTS);
            push_byte(BYTE_W'(announced));
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(9) != 0 && gen_count > 0)
                  m = $urandom_range(1, gen_count);
               else
                  m = $urandom_range(255);
               case ($urandom_range(3))
                  0: bits = BITS_W'($urandom_range(16'hFFFF));
                  1: bits = last_sent[m];
                  default: bits = last_sent[m] ^ (16'h1 << $urandom_range(15));
               endcase
               push_triple(m, bits);
            end
            // cut a triple short now and then
            if ($urandom_range(7) == 0) begin
               push_byte(BYTE_W'($urandom_range(1, MAX_MODULES)));
               if ($urandom_range(1) == 0)
                  push_byte(BYTE_W'($urandom_range(255)));
            end
            push_byte(CR_BYTE);
         end else if (pick < 90) begin
            push_byte(BYTE_W'($urandom_range(255)));
            repeat ($urandom_range(5))
               push_byte(BYTE_W'($urandom_range(255)));
            push_byte(CR_BYTE);
         end else begin
            case ($urandom_range(2))
               0: push_byte(TYPE_INPUTS);
               1: push_byte(TYPE_SETUP);
               default: ;
            endcase
            push_byte(CR_BYTE);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty frame
      push_byte(CR_BYTE);
      // oversized setup count saturates, trailing byte dropped
      push_byte(TYPE_SETUP); push_byte(8'hFF); push_byte(8'h41); push_byte(CR_BYTE);
      gen_count = MAX_MODULES;
      // first and last module, module zero, top module number, extra triple ignored
      push_byte(TYPE_INPUTS); push_byte(8'd4);
      push_triple(1, 16'hFFFF);
      push_triple(MAX_MODULES, 16'h0000);
      push_triple(0, 16'hAA55);
      push_triple(255, 16'h0180);
      push_triple(1, 16'h0000);
      push_byte(CR_BYTE);
      // short frame, foreign frame type, partial triple
      push_byte(TYPE_INPUTS); push_byte(CR_BYTE);
      push_byte(8'h78); push_byte(CR_BYTE);
      push_byte(TYPE_INPUTS); push_byte(8'd1); push_byte(8'd5); push_byte(CR_BYTE);
      wait_idle();

      set_chains(0, 0);
      random_phase(10);
      wait_idle();

      // fill the block while the receiver holds off, sender back to back
      set_chains(MAX_MODULES, MAX_MODULES);
      calm_phase = 1'b1;
      hold_asks++;
      push_byte(TYPE_SETUP); push_byte(BYTE_W'(MAX_MODULES)); push_byte(CR_BYTE);
      gen_count = MAX_MODULES;
      push_byte(TYPE_INPUTS); push_byte(8'd6);
      for (int i = 1; i <= 6; i++)
         push_triple(i, BITS_W'($urandom_range(16'hFFFF)));
      push_byte(CR_BYTE);
      random_phase(8);
      wait_idle();
      calm_phase = 1'b0;

      set_chains(0, MAX_MODULES);
      random_phase(10);
      wait_idle();

      set_chains(MAX_MODULES, 0);
      random_phase(10);
      wait_idle();

      set_chains($urandom_range(MAX_MODULES), $urandom_range(MAX_MODULES));
      random_phase(10);
      wait_idle();

      if (error_count == 0)
         $display("[feedback_report_change_detector_top] OK");
      else
         $display("[feedback_report_change_detector_top] ERROR");
      $finish;
   end

   // drop out if the run hangs
   initial begin
      #2_000_000;
      $display("[feedback_report_change_detector_top] ERROR");
      $finish;
   end

endmodule
